>>> hw/rtl/gti_pkg.sv
package gti_pkg;

    localparam logic [1:0] FUNC_WR_GRID   = 2'd0;
    localparam logic [1:0] FUNC_WR_SAMPLE = 2'd1;
    localparam logic [1:0] FUNC_QUERY     = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FEW   = 2'd2;

    localparam logic [1:0] CFG_POINTS  = 2'd0;
    localparam logic [1:0] CFG_COLUMNS = 2'd1;
    localparam logic [1:0] CFG_MODE    = 2'd2;

    localparam logic [3:0] STEP_S01   = 4'd0;
    localparam logic [3:0] STEP_S12   = 4'd1;
    localparam logic [3:0] STEP_D2    = 4'd2;
    localparam logic [3:0] STEP_T     = 4'd3;
    localparam logic [3:0] STEP_INNER = 4'd4;
    localparam logic [3:0] STEP_P     = 4'd5;
    localparam logic [3:0] STEP_RND   = 4'd6;
    localparam logic [3:0] STEP_FIN   = 4'd7;
    localparam logic [3:0] STEP_COPY  = 4'd8;
    localparam logic [3:0] STEP_ZERO  = 4'd9;

    localparam int FRAC_SHIFT = 28;
    localparam int ROW_W      = 8;
    localparam int COL_W      = 10;

    typedef struct packed {
        logic [1:0]         func;
        logic [3:0]         point_index;
        logic [5:0]         column_index;
        logic signed [31:0] energy;
        logic signed [31:0] sample_re;
        logic signed [31:0] sample_im;
    } item_t;

    typedef struct packed {
        logic signed [31:0] result_re;
        logic signed [31:0] result_im;
        logic [5:0]         column;
        logic               last;
        logic [1:0]         status;
    } result_t;

    typedef struct packed {
        logic             accept;
        logic [ROW_W-1:0] grid_addr;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col_addr;
        logic [1:0]       k;
        logic [3:0]       step;
        logic             exec;
        logic             start;
        logic             side;
        logic             quad;
        logic             srch_latch;
        logic             ldx;
        logic             ldy;
    } cmd_t;

    typedef struct packed {
        logic eq;
        logic between;
        logic mid_lo;
        logic unit_done;
    } stat_t;

    // Signed value from sign and magnitude, saturated to 64 bits.
    function automatic logic signed [63:0] from_mag(input logic neg, input logic [64:0] m);
        logic signed [63:0] r;
        if (!neg) begin
            r = (m > 65'h0_7FFF_FFFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(m[63:0]);
        end else if (m > 65'h0_8000_0000_0000_0000) begin
            r = 64'sh8000_0000_0000_0000;
        end else begin
            r = $signed(64'd0 - m[63:0]);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/gti_div.sv
module gti_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [33:0] den,
    output logic               done,
    output logic signed [63:0] quo
);

    logic [6:0]  cnt_reg;
    logic        run_reg;
    logic        fin_reg;
    logic        done_reg;
    logic        neg_reg;
    logic        zero_reg;
    logic [64:0] un_reg;
    logic [33:0] rem_reg;
    logic [33:0] ud_reg;
    logic signed [63:0] quo_reg;

    logic [63:0] num_mag;
    logic [33:0] den_mag;
    logic [34:0] rem_sh;
    logic        fits;

    assign num_mag = num[63] ? (64'd0 - num) : num;
    assign den_mag = den[33] ? (34'd0 - den) : den;
    assign rem_sh  = {rem_reg, un_reg[64]};
    assign fits    = rem_sh >= {1'b0, ud_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= 7'd65;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end else if (fin_reg) begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            neg_reg  <= num[63] ^ den[33];
            zero_reg <= (den == 34'sd0);
            ud_reg   <= den_mag;
            un_reg   <= {1'b0, num_mag} + {32'd0, den_mag[33:1]};
            rem_reg  <= '0;
        end else if (run_reg) begin
            rem_reg <= fits ? 34'(rem_sh - {1'b0, ud_reg}) : rem_sh[33:0];
            un_reg  <= {un_reg[63:0], fits};
        end else if (fin_reg) begin
            quo_reg <= zero_reg ? 64'sd0 : gti_pkg::from_mag(neg_reg, un_reg);
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> hw/rtl/gti_mul.sv
module gti_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [32:0] a,
    input  logic signed [63:0] b,
    output logic               done,
    output logic signed [63:0] prod
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_LO   = 3'd1;
    localparam logic [2:0] PH_HI   = 3'd2;
    localparam logic [2:0] PH_SUM  = 3'd3;
    localparam logic [2:0] PH_SAT  = 3'd4;

    logic [2:0]  ph_reg;
    logic        done_reg;
    logic        neg_reg;
    logic [32:0] ua_reg;
    logic [63:0] ub_reg;
    logic [64:0] pp_reg;
    logic [96:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic [64:0] acc_clip;

    assign acc_clip = (|acc_reg[96:65]) ? {65{1'b1}} : acc_reg[64:0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (ph_reg)
                PH_IDLE: if (start) ph_reg <= PH_LO;
                PH_LO:   ph_reg <= PH_HI;
                PH_HI:   ph_reg <= PH_SUM;
                PH_SUM:  ph_reg <= PH_SAT;
                PH_SAT:
                begin
                    ph_reg   <= PH_IDLE;
                    done_reg <= 1'b1;
                end
                default: ph_reg <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        case (ph_reg)
            PH_IDLE:
            begin
                if (start) begin
                    neg_reg <= a[32] ^ b[63];
                    ua_reg  <= a[32] ? (33'd0 - a) : a;
                    ub_reg  <= b[63] ? (64'd0 - b) : b;
                end
            end
            PH_LO: pp_reg <= {32'd0, ua_reg} * {33'd0, ub_reg[31:0]};
            PH_HI:
            begin
                acc_reg <= {32'd0, pp_reg};
                pp_reg  <= {32'd0, ua_reg} * {33'd0, ub_reg[63:32]};
            end
            PH_SUM: acc_reg <= acc_reg + {pp_reg, 32'd0};
            PH_SAT: prod_reg <= gti_pkg::from_mag(neg_reg, acc_clip);
            default: ;
        endcase
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

>>> hw/rtl/gti_datapath.sv
module gti_datapath #(
    parameter int GRID_POINTS = 16,
    parameter int COLUMNS     = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gti_pkg::item_t      item,
    input  gti_pkg::cmd_t       cmd,
    output gti_pkg::stat_t      stat,
    output logic signed [31:0]  result_re,
    output logic signed [31:0]  result_im
);

    localparam int PW    = $clog2(GRID_POINTS);
    localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int DEPTH = GRID_POINTS * (1 << CW);

    logic signed [31:0] grid_mem [GRID_POINTS];
    logic [63:0]        smp_mem [DEPTH];

    logic signed [31:0] grid_q_reg;
    logic [63:0]        smp_q_reg;
    logic signed [31:0] e_reg;
    logic signed [31:0] prev_reg;
    logic signed [31:0] x_reg [3];
    logic [63:0]        y_reg [3];
    logic signed [63:0] s01_reg, s12_reg, d2_reg, t_reg, inner_reg, p_reg, r_reg;
    logic signed [31:0] res_re_reg, res_im_reg;

    logic signed [31:0] ys0, ys1, ys2;
    logic signed [32:0] dy, dx;
    logic signed [63:0] div_num;
    logic signed [33:0] div_den;
    logic signed [32:0] mul_a;
    logic signed [63:0] mul_b;
    logic               div_start, mul_start, div_done, mul_done;
    logic signed [63:0] div_quo, mul_prod;
    logic [63:0]        p_mag;
    logic [64:0]        p_rnd;
    logic signed [63:0] fin_sum;
    logic signed [31:0] fin_out;
    logic signed [33:0] mid_sum, e_twice;
    logic               wr_grid, wr_smp;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        return s[63:0];
    endfunction

    assign wr_grid = cmd.accept && (item.func == gti_pkg::FUNC_WR_GRID)
                     && (32'(item.point_index) < GRID_POINTS);
    assign wr_smp  = cmd.accept && (item.func == gti_pkg::FUNC_WR_SAMPLE)
                     && (32'(item.point_index) < GRID_POINTS)
                     && (32'(item.column_index) < COLUMNS);

    always_ff @(posedge clk) begin
        if (wr_grid) begin
            grid_mem[PW'(item.point_index)] <= item.energy;
        end
        grid_q_reg <= grid_mem[PW'(cmd.grid_addr)];
    end

    always_ff @(posedge clk) begin
        if (wr_smp) begin
            smp_mem[{PW'(item.point_index), CW'(item.column_index)}] <=
                {item.sample_re, item.sample_im};
        end
        smp_q_reg <= smp_mem[{PW'(cmd.row), CW'(cmd.col_addr)}];
    end

    assign ys0 = cmd.side ? $signed(y_reg[0][31:0]) : $signed(y_reg[0][63:32]);
    assign ys1 = cmd.side ? $signed(y_reg[1][31:0]) : $signed(y_reg[1][63:32]);
    assign ys2 = cmd.side ? $signed(y_reg[2][31:0]) : $signed(y_reg[2][63:32]);

    always_comb begin
        dy      = (cmd.step == gti_pkg::STEP_S12) ? (33'(ys2) - 33'(ys1))
                                                  : (33'(ys1) - 33'(ys0));
        case (cmd.step)
            gti_pkg::STEP_S12: dx = 33'(x_reg[2]) - 33'(x_reg[1]);
            gti_pkg::STEP_D2:  dx = 33'(x_reg[2]) - 33'(x_reg[0]);
            default:           dx = 33'(x_reg[1]) - 33'(x_reg[0]);
        endcase
        div_den = 34'(dx);
        if (cmd.step == gti_pkg::STEP_D2) begin
            div_num = s12_reg - s01_reg;
        end else begin
            div_num = $signed({{3{dy[32]}}, dy, 28'd0});
        end
        if (cmd.step == gti_pkg::STEP_T) begin
            mul_a = 33'(e_reg) - 33'(x_reg[1]);
            mul_b = d2_reg;
        end else begin
            mul_a = 33'(e_reg) - 33'(x_reg[0]);
            mul_b = inner_reg;
        end
    end

    assign div_start = cmd.start && (cmd.step == gti_pkg::STEP_S01
                       || cmd.step == gti_pkg::STEP_S12 || cmd.step == gti_pkg::STEP_D2);
    assign mul_start = cmd.start && (cmd.step == gti_pkg::STEP_T
                       || cmd.step == gti_pkg::STEP_P);

    gti_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    gti_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign p_mag   = p_reg[63] ? (64'd0 - p_reg) : p_reg;
    assign p_rnd   = {1'b0, p_mag} + (65'd1 << (gti_pkg::FRAC_SHIFT - 1));
    assign fin_sum = sat_add(64'(ys0), r_reg);
    always_comb begin
        if (fin_sum > 64'sd2147483647) begin
            fin_out = 32'sh7FFF_FFFF;
        end else if (fin_sum < -64'sd2147483648) begin
            fin_out = 32'sh8000_0000;
        end else begin
            fin_out = fin_sum[31:0];
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.accept) e_reg <= item.energy;
        if (cmd.srch_latch) prev_reg <= grid_q_reg;
        if (cmd.ldx) x_reg[cmd.k] <= grid_q_reg;
        if (cmd.ldy) y_reg[cmd.k] <= smp_q_reg;
        if (div_done || mul_done) begin
            case (cmd.step)
                gti_pkg::STEP_S01: s01_reg <= div_quo;
                gti_pkg::STEP_S12: s12_reg <= div_quo;
                gti_pkg::STEP_D2:  d2_reg  <= div_quo;
                gti_pkg::STEP_T:   t_reg   <= mul_prod;
                gti_pkg::STEP_P:   p_reg   <= mul_prod;
                default: ;
            endcase
        end
        if (cmd.exec) begin
            case (cmd.step)
                gti_pkg::STEP_INNER: inner_reg <= cmd.quad ? sat_add(s01_reg, t_reg) : s01_reg;
                gti_pkg::STEP_RND:
                    r_reg <= gti_pkg::from_mag(p_reg[63],
                                               {28'd0, p_rnd[64:gti_pkg::FRAC_SHIFT]});
                gti_pkg::STEP_FIN:
                begin
                    if (cmd.side) res_im_reg <= fin_out;
                    else res_re_reg <= fin_out;
                end
                gti_pkg::STEP_COPY:
                begin
                    res_re_reg <= $signed(y_reg[0][63:32]);
                    res_im_reg <= $signed(y_reg[0][31:0]);
                end
                gti_pkg::STEP_ZERO:
                begin
                    res_re_reg <= '0;
                    res_im_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    assign e_twice = {e_reg[31], e_reg, 1'b0};
    assign mid_sum = 34'(prev_reg) + 34'(grid_q_reg);

    assign stat.eq        = (grid_q_reg == e_reg);
    assign stat.between   = (prev_reg < e_reg) && (e_reg < grid_q_reg);
    assign stat.mid_lo    = (e_twice < mid_sum);
    assign stat.unit_done = div_done || mul_done;

    assign result_re = res_re_reg;
    assign result_im = res_im_reg;

endmodule

>>> hw/rtl/gti_ctrl.sv
module gti_ctrl #(
    parameter int GRID_POINTS = 16,
    parameter int COLUMNS     = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  logic [1:0]      item_func,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [6:0]      cfg_data,
    output logic            result_valid,
    input  logic            result_stall,
    output logic [5:0]      column,
    output logic            last,
    output logic [1:0]      status,
    output gti_pkg::cmd_t   cmd,
    input  gti_pkg::stat_t  stat
);

    localparam int PW      = $clog2(GRID_POINTS);
    localparam int NW      = $clog2(GRID_POINTS + 1);
    localparam int COL_MAX = (COLUMNS < 64) ? COLUMNS : 64;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRD  = 4'd1;
    localparam logic [3:0] S_SCMP = 4'd2;
    localparam logic [3:0] S_XRD  = 4'd3;
    localparam logic [3:0] S_XCAP = 4'd4;
    localparam logic [3:0] S_COL  = 4'd5;
    localparam logic [3:0] S_YRD  = 4'd6;
    localparam logic [3:0] S_YCAP = 4'd7;
    localparam logic [3:0] S_OP   = 4'd8;
    localparam logic [3:0] S_WAIT = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [4:0]    pts_reg, pts_next;
    logic [6:0]    cols_reg, cols_next;
    logic          mode_reg, mode_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] iz_reg, iz_next;
    logic [5:0]    cm1_reg, cm1_next;
    logic [5:0]    c_reg, c_next;
    logic          quad_reg, quad_next;
    logic [PW-1:0] base_reg, base_next;
    logic          exact_reg, exact_next;
    logic [1:0]    status_reg, status_next;
    logic [1:0]    k_reg, k_next;
    logic          side_reg, side_next;
    logic [3:0]    step_reg, step_next;

    logic accept;
    logic unit_step;
    logic advance;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            pts_reg    <= 5'd2;
            cols_reg   <= 7'd64;
            mode_reg   <= 1'b0;
            n_reg      <= '0;
            iz_reg     <= '0;
            cm1_reg    <= '0;
            c_reg      <= '0;
            quad_reg   <= 1'b0;
            base_reg   <= '0;
            exact_reg  <= 1'b0;
            status_reg <= gti_pkg::STATUS_OK;
            k_reg      <= '0;
            side_reg   <= 1'b0;
            step_reg   <= gti_pkg::STEP_ZERO;
        end else begin
            state_reg  <= state_next;
            pts_reg    <= pts_next;
            cols_reg   <= cols_next;
            mode_reg   <= mode_next;
            n_reg      <= n_next;
            iz_reg     <= iz_next;
            cm1_reg    <= cm1_next;
            c_reg      <= c_next;
            quad_reg   <= quad_next;
            base_reg   <= base_next;
            exact_reg  <= exact_next;
            status_reg <= status_next;
            k_reg      <= k_next;
            side_reg   <= side_next;
            step_reg   <= step_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign unit_step  = (step_reg == gti_pkg::STEP_S01) || (step_reg == gti_pkg::STEP_S12)
                     || (step_reg == gti_pkg::STEP_D2) || (step_reg == gti_pkg::STEP_T)
                     || (step_reg == gti_pkg::STEP_P);

    always_comb begin
        int n_i;
        int c_i;
        int hit_i;
        int base_i;

        state_next  = state_reg;
        pts_next    = pts_reg;
        cols_next   = cols_reg;
        mode_next   = mode_reg;
        n_next      = n_reg;
        iz_next     = iz_reg;
        cm1_next    = cm1_reg;
        c_next      = c_reg;
        quad_next   = quad_reg;
        base_next   = base_reg;
        exact_next  = exact_reg;
        status_next = status_reg;
        k_next      = k_reg;
        side_next   = side_reg;
        step_next   = step_reg;
        advance     = 1'b0;
        n_i         = 0;
        c_i         = 0;
        hit_i       = 0;
        base_i      = 0;

        cmd            = '0;
        cmd.accept     = accept;
        cmd.quad       = quad_reg;
        cmd.step       = step_reg;
        cmd.side       = side_reg;
        cmd.k          = k_reg;
        cmd.row        = gti_pkg::ROW_W'(int'(base_reg) + int'(k_reg));
        cmd.col_addr   = gti_pkg::COL_W'(c_reg);
        if (state_reg == S_XRD || state_reg == S_XCAP) begin
            cmd.grid_addr = gti_pkg::ROW_W'(int'(base_reg) + int'(k_reg));
        end else begin
            cmd.grid_addr = gti_pkg::ROW_W'(iz_reg);
        end

        if (cfg_we) begin
            case (cfg_index)
                gti_pkg::CFG_POINTS:  pts_next  = cfg_data[4:0];
                gti_pkg::CFG_COLUMNS: cols_next = cfg_data;
                gti_pkg::CFG_MODE:    mode_next = cfg_data[0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && item_func == gti_pkg::FUNC_QUERY) begin
                    n_i = (int'(pts_reg) > GRID_POINTS) ? GRID_POINTS : int'(pts_reg);
                    c_i = int'(cols_reg);
                    if (c_i > COL_MAX) c_i = COL_MAX;
                    if (c_i < 1) c_i = 1;
                    n_next      = NW'(n_i);
                    cm1_next    = 6'(c_i - 1);
                    c_next      = '0;
                    quad_next   = mode_reg;
                    exact_next  = 1'b0;
                    iz_next     = '0;
                    status_next = gti_pkg::STATUS_OK;
                    if (mode_reg && n_i < 3) begin
                        status_next = gti_pkg::STATUS_FEW;
                        state_next  = S_COL;
                    end else if (n_i == 0) begin
                        status_next = gti_pkg::STATUS_RANGE;
                        state_next  = S_COL;
                    end else begin
                        state_next = S_SRD;
                    end
                end
            end
            S_SRD: state_next = S_SCMP;
            S_SCMP:
            begin
                cmd.srch_latch = 1'b1;
                if (iz_reg != '0 && stat.between) begin
                    hit_i = int'(iz_reg) - 1;
                    if (!quad_reg) base_i = hit_i;
                    else if (hit_i < 2) base_i = 0;
                    else if (hit_i > int'(n_reg) - 3) base_i = int'(n_reg) - 3;
                    else if (stat.mid_lo) base_i = hit_i - 1;
                    else base_i = hit_i;
                    base_next  = PW'(base_i);
                    k_next     = '0;
                    state_next = S_XRD;
                end else if (stat.eq) begin
                    base_next  = PW'(iz_reg);
                    exact_next = 1'b1;
                    state_next = S_COL;
                end else if (int'(iz_reg) + 1 < int'(n_reg)) begin
                    iz_next    = NW'(int'(iz_reg) + 1);
                    state_next = S_SRD;
                end else begin
                    status_next = gti_pkg::STATUS_RANGE;
                    state_next  = S_COL;
                end
            end
            S_XRD: state_next = S_XCAP;
            S_XCAP:
            begin
                cmd.ldx = 1'b1;
                if (k_reg == (quad_reg ? 2'd2 : 2'd1)) begin
                    k_next     = '0;
                    state_next = S_COL;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_XRD;
                end
            end
            S_COL:
            begin
                k_next = '0;
                if (status_reg != gti_pkg::STATUS_OK) begin
                    step_next  = gti_pkg::STEP_ZERO;
                    state_next = S_OP;
                end else begin
                    state_next = S_YRD;
                end
            end
            S_YRD: state_next = S_YCAP;
            S_YCAP:
            begin
                cmd.ldy = 1'b1;
                if (exact_reg || k_reg == (quad_reg ? 2'd2 : 2'd1)) begin
                    k_next     = '0;
                    side_next  = 1'b0;
                    step_next  = exact_reg ? gti_pkg::STEP_COPY : gti_pkg::STEP_S01;
                    state_next = S_OP;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_YRD;
                end
            end
            S_OP:
            begin
                if (unit_step) begin
                    cmd.start  = 1'b1;
                    state_next = S_WAIT;
                end else begin
                    cmd.exec = 1'b1;
                    advance  = 1'b1;
                end
            end
            S_WAIT: advance = stat.unit_done;
            S_OUT:
            begin
                if (!result_stall) begin
                    if (c_reg == cm1_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        c_next     = c_reg + 6'd1;
                        state_next = S_COL;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (advance) begin
            state_next = S_OP;
            case (step_reg)
                gti_pkg::STEP_S01:   step_next = quad_reg ? gti_pkg::STEP_S12
                                                          : gti_pkg::STEP_INNER;
                gti_pkg::STEP_S12:   step_next = gti_pkg::STEP_D2;
                gti_pkg::STEP_D2:    step_next = gti_pkg::STEP_T;
                gti_pkg::STEP_T:     step_next = gti_pkg::STEP_INNER;
                gti_pkg::STEP_INNER: step_next = gti_pkg::STEP_P;
                gti_pkg::STEP_P:     step_next = gti_pkg::STEP_RND;
                gti_pkg::STEP_RND:   step_next = gti_pkg::STEP_FIN;
                gti_pkg::STEP_FIN:
                begin
                    if (!side_reg) begin
                        side_next = 1'b1;
                        step_next = gti_pkg::STEP_S01;
                    end else begin
                        state_next = S_OUT;
                    end
                end
                default: state_next = S_OUT;
            endcase
        end
    end

    assign result_valid = (state_reg == S_OUT);
    assign column       = c_reg;
    assign last         = (c_reg == cm1_reg);
    assign status       = status_reg;

endmodule

>>> hw/rtl/grid_table_interpolator.sv
// Channel   Direction  Handshake              Payload
// item      in         item_valid/item_stall  gti_pkg::item_t
// result    out        result_valid/result_stall gti_pkg::result_t
// cfg       in         cfg_we                 cfg_index, cfg_data
//
// A write transaction is taken only while the block is idle. A query searches the grid
// point by point, reading and then comparing each point, loads its window, then works
// through each column in turn, linear or quadratic, plus the output handshake.
// The shared divider, one quotient bit per cycle, takes most of the time per column.
// Reset clears only control and configuration; the grid and sample memories are
// undefined until written. A stalled result holds the block until it is taken.
module grid_table_interpolator #(
    parameter int GRID_POINTS = 16,
    parameter int COLUMNS     = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  gti_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_stall,
    output gti_pkg::result_t  result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [6:0]        cfg_data
);

    gti_pkg::cmd_t  cmd;
    gti_pkg::stat_t stat;

    gti_ctrl #(
        .GRID_POINTS (GRID_POINTS),
        .COLUMNS     (COLUMNS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_func    (item.func),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .column       (result.column),
        .last         (result.last),
        .status       (result.status),
        .cmd          (cmd),
        .stat         (stat)
    );

    gti_datapath #(
        .GRID_POINTS (GRID_POINTS),
        .COLUMNS     (COLUMNS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .result_re (result.result_re),
        .result_im (result.result_im)
    );

    a_busy_when_presenting: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("result presented while items are taken");

    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && item.func == gti_pkg::FUNC_QUERY) |=> item_stall)
        else $error("query transaction did not start work");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != gti_pkg::STATUS_OK)
        |-> (result.result_re == 32'sd0 && result.result_im == 32'sd0))
        else $error("error status with nonzero result");

endmodule
